// ===== design/cpu_control_flow_sequencer_macros.svh =====
// Assertion helpers shared by the input-stage and execute modules.
// Each macro expects clk and rst_n in scope.
`ifndef CPU_CONTROL_FLOW_SEQUENCER_MACROS_SVH
`define CPU_CONTROL_FLOW_SEQUENCER_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define CFS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must be followed by a consequence in the next cycle
`define CFS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cfs_pkg.sv =====
`default_nettype none

package cfs_pkg;

    // Instruction kinds
    localparam logic [4:0] KIND_BRA      = 5'd8;
    localparam logic [4:0] KIND_BRL      = 5'd9;
    localparam logic [4:0] KIND_JMP_ABS  = 5'd10;
    localparam logic [4:0] KIND_JML_LONG = 5'd11;
    localparam logic [4:0] KIND_JMP_IND  = 5'd12;
    localparam logic [4:0] KIND_JMP_IDX  = 5'd13;
    localparam logic [4:0] KIND_JML_IND  = 5'd14;
    localparam logic [4:0] KIND_JSR_ABS  = 5'd15;
    localparam logic [4:0] KIND_JSL      = 5'd16;
    localparam logic [4:0] KIND_JSR_IDX  = 5'd17;
    localparam logic [4:0] KIND_RTI      = 5'd18;
    localparam logic [4:0] KIND_RTS      = 5'd19;
    localparam logic [4:0] KIND_RTL      = 5'd20;
    localparam logic [4:0] NUM_KINDS     = 5'd21;

    // Bus request codes
    localparam logic [2:0] BUS_FETCH = 3'd0;
    localparam logic [2:0] BUS_BANK0 = 3'd1;
    localparam logic [2:0] BUS_PBANK = 3'd2;
    localparam logic [2:0] BUS_PULL  = 3'd3;
    localparam logic [2:0] BUS_PUSH  = 3'd4;
    localparam logic [2:0] BUS_IDLE  = 3'd5;
    localparam logic [2:0] BUS_NONE  = 3'd6;

    // Forced status bits in emulation mode
    localparam logic [7:0] EMU_STATUS_MASK = 8'h30;

    // Micro-operations of one bus cycle
    typedef enum logic [4:0] {
        CYC_END, CYC_BR, CYC_C6, CYC_IO, CYC_FRL, CYC_FRH, CYC_FRB,
        CYC_FAL, CYC_FAH, CYC_FAB, CYC_R0L, CYC_R0H, CYC_R0B, CYC_RPL,
        CYC_RPH, CYC_PSB, CYC_PSHD, CYC_PSH, CYC_PSL, CYC_PLP, CYC_PLL,
        CYC_PLH, CYC_PLB
    } cyc_op_t;

    typedef struct packed {
        logic        mode;
        logic [4:0]  op_kind;
        logic [23:0] start_pc;
        logic [7:0]  status_flags;
        logic        emulation;
        logic [15:0] index_x;
        logic [7:0]  bus_data;
    } item_t;

    typedef struct packed {
        logic [2:0]  bus_kind;
        logic [23:0] bus_address;
        logic [7:0]  push_byte;
        logic        final_cycle;
        logic        done_res;
        logic [23:0] new_pc;
        logic        status_load;
        logic [7:0]  status_value;
        logic        clear_index_high;
    } result_t;

    // Cycle program of each instruction kind; s counts from 1
    function automatic cyc_op_t prog_op(input logic [4:0] kind, input logic [3:0] s);
        cyc_op_t op;
        op = CYC_END;
        if (kind <= KIND_BRA)
        begin
            unique case (s)
                4'd1:    op = CYC_BR;
                4'd2:    op = CYC_C6;
                4'd3:    op = CYC_IO;
                default: op = CYC_END;
            endcase
        end
        else
        begin
            unique case (kind)
                KIND_BRL:
                begin
                    unique case (s)
                        4'd1:    op = CYC_FRL;
                        4'd2:    op = CYC_FRH;
                        4'd3:    op = CYC_IO;
                        default: op = CYC_END;
                    endcase
                end
                KIND_JMP_ABS:
                begin
                    unique case (s)
                        4'd1:    op = CYC_FRL;
                        4'd2:    op = CYC_FRH;
                        default: op = CYC_END;
                    endcase
                end
                KIND_JML_LONG:
                begin
                    unique case (s)
                        4'd1:    op = CYC_FRL;
                        4'd2:    op = CYC_FRH;
                        4'd3:    op = CYC_FRB;
                        default: op = CYC_END;
                    endcase
                end
                KIND_JMP_IND:
                begin
                    unique case (s)
                        4'd1:    op = CYC_FAL;
                        4'd2:    op = CYC_FAH;
                        4'd3:    op = CYC_R0L;
                        4'd4:    op = CYC_R0H;
                        default: op = CYC_END;
                    endcase
                end
                KIND_JMP_IDX:
                begin
                    unique case (s)
                        4'd1:    op = CYC_FAL;
                        4'd2:    op = CYC_FAH;
                        4'd3:    op = CYC_IO;
                        4'd4:    op = CYC_RPL;
                        4'd5:    op = CYC_RPH;
                        default: op = CYC_END;
                    endcase
                end
                KIND_JML_IND:
                begin
                    unique case (s)
                        4'd1:    op = CYC_FAL;
                        4'd2:    op = CYC_FAH;
                        4'd3:    op = CYC_R0L;
                        4'd4:    op = CYC_R0H;
                        4'd5:    op = CYC_R0B;
                        default: op = CYC_END;
                    endcase
                end
                KIND_JSR_ABS:
                begin
                    unique case (s)
                        4'd1:    op = CYC_FAL;
                        4'd2:    op = CYC_FAH;
                        4'd3:    op = CYC_IO;
                        4'd4:    op = CYC_PSHD;
                        4'd5:    op = CYC_PSL;
                        default: op = CYC_END;
                    endcase
                end
                KIND_JSL:
                begin
                    unique case (s)
                        4'd1:    op = CYC_FAL;
                        4'd2:    op = CYC_FAH;
                        4'd3:    op = CYC_PSB;
                        4'd4:    op = CYC_IO;
                        4'd5:    op = CYC_FAB;
                        4'd6:    op = CYC_PSHD;
                        4'd7:    op = CYC_PSL;
                        default: op = CYC_END;
                    endcase
                end
                KIND_JSR_IDX:
                begin
                    unique case (s)
                        4'd1:    op = CYC_FAL;
                        4'd2:    op = CYC_PSH;
                        4'd3:    op = CYC_PSL;
                        4'd4:    op = CYC_FAH;
                        4'd5:    op = CYC_IO;
                        4'd6:    op = CYC_RPL;
                        4'd7:    op = CYC_RPH;
                        default: op = CYC_END;
                    endcase
                end
                KIND_RTI:
                begin
                    unique case (s)
                        4'd1:    op = CYC_IO;
                        4'd2:    op = CYC_IO;
                        4'd3:    op = CYC_PLP;
                        4'd4:    op = CYC_PLL;
                        4'd5:    op = CYC_PLH;
                        4'd6:    op = CYC_PLB;
                        default: op = CYC_END;
                    endcase
                end
                KIND_RTS:
                begin
                    unique case (s)
                        4'd1:    op = CYC_IO;
                        4'd2:    op = CYC_IO;
                        4'd3:    op = CYC_PLL;
                        4'd4:    op = CYC_PLH;
                        4'd5:    op = CYC_IO;
                        default: op = CYC_END;
                    endcase
                end
                KIND_RTL:
                begin
                    unique case (s)
                        4'd1:    op = CYC_IO;
                        4'd2:    op = CYC_IO;
                        4'd3:    op = CYC_PLL;
                        4'd4:    op = CYC_PLH;
                        4'd5:    op = CYC_PLB;
                        default: op = CYC_END;
                    endcase
                end
                default: op = CYC_END;
            endcase
        end
        return op;
    endfunction

endpackage

`default_nettype wire

// ===== design/cfs_in_stage.sv =====
`default_nettype none

`include "cpu_control_flow_sequencer_macros.svh"

module cfs_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_ready,
    input  wire cfs_pkg::item_t item,
    input  wire logic          advance,
    output logic               held_valid,
    output cfs_pkg::item_t     held_item
);

    logic           valid_reg;
    logic           valid_next;
    cfs_pkg::item_t item_reg;

    // Take a new transfer whenever the slot is empty or drains this cycle
    assign item_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_valid && item_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on each transfer
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    `CFS_ASSERT_NEXT(a_held_item_kept, valid_reg && !advance,
        valid_reg && $stable(item_reg), "held item lost or changed while waiting")

endmodule

`default_nettype wire

// ===== design/cfs_exec.sv =====
`default_nettype none

`include "cpu_control_flow_sequencer_macros.svh"

module cfs_exec (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire cfs_pkg::item_t item,
    output cfs_pkg::result_t    step_result
);

    // Instruction state
    logic [2:0]  step_reg;
    logic [4:0]  kind_reg;
    logic [23:0] pc_reg;
    logic [23:0] oa_reg;
    logic [23:0] rb_reg;
    logic [7:0]  page_reg;
    logic [7:0]  flags_reg;
    logic        emu_reg;
    logic [15:0] index_reg;

    logic [2:0]  step_next;
    logic [4:0]  kind_next;
    logic [23:0] pc_next;
    logic [23:0] oa_next;
    logic [23:0] rb_next;
    logic [7:0]  page_next;
    logic [7:0]  flags_next;
    logic        emu_next;
    logic [15:0] index_next;

    cfs_pkg::cyc_op_t cur_op;
    cfs_pkg::cyc_op_t req_op;
    logic        emit;
    logic [3:0]  seq_step;
    logic [15:0] pcw_inc;
    logic [15:0] pcw_dec;
    logic [15:0] br_target;
    logic [7:0]  status_word;
    logic [15:0] aw;
    logic [15:0] aw_idx;
    logic [15:0] req_pcw;
    logic [15:0] req_pcw_dec;

    // Branch condition from the latched flags
    function automatic logic branch_taken(input logic [4:0] kind, input logic [7:0] flags);
        logic b;
        b = 1'b0;
        unique case (kind[2:1])
            2'd0: b = flags[0];
            2'd1: b = flags[1];
            2'd2: b = flags[7];
            2'd3: b = flags[6];
            default: b = 1'b0;
        endcase
        return (kind == cfs_pkg::KIND_BRA) || (b == kind[0]);
    endfunction

    // Whether cycle s closes the instruction
    function automatic logic is_last(input logic [4:0] kind, input logic [3:0] s,
                                     input logic [7:0] flags, input logic emu);
        logic last;
        last = 1'b0;
        if (cfs_pkg::prog_op(kind, s) == cfs_pkg::CYC_BR && !branch_taken(kind, flags))
        begin
            last = 1'b1;
        end
        else if (kind == cfs_pkg::KIND_RTI && s == 4'd5 && emu)
        begin
            last = 1'b1;
        end
        else if (cfs_pkg::prog_op(kind, s + 4'd1) == cfs_pkg::CYC_END)
        begin
            last = 1'b1;
        end
        return last;
    endfunction

    // Work out one bus cycle: start an instruction or absorb the returned byte, then issue the next request
    always_comb
    begin
        step_next   = step_reg;
        kind_next   = kind_reg;
        pc_next     = pc_reg;
        oa_next     = oa_reg;
        rb_next     = rb_reg;
        page_next   = page_reg;
        flags_next  = flags_reg;
        emu_next    = emu_reg;
        index_next  = index_reg;
        emit        = 1'b0;
        seq_step    = {1'b0, step_reg};
        status_word = item.bus_data | (emu_reg ? cfs_pkg::EMU_STATUS_MASK : 8'h00);
        pcw_inc     = pc_reg[15:0] + 16'd1;
        pcw_dec     = pc_reg[15:0] - 16'd1;
        br_target   = pcw_inc + {{8{item.bus_data[7]}}, item.bus_data};
        cur_op      = cfs_pkg::prog_op(kind_reg, {1'b0, step_reg});

        step_result                  = '0;
        step_result.bus_kind         = cfs_pkg::BUS_NONE;

        if (!item.mode)
        begin
            // Start: latch the instruction context
            kind_next  = item.op_kind;
            pc_next    = item.start_pc;
            flags_next = item.status_flags;
            emu_next   = item.emulation;
            index_next = item.index_x;
            oa_next    = 24'h000000;
            rb_next    = 24'h000000;
            page_next  = 8'h00;
            if (item.op_kind >= cfs_pkg::NUM_KINDS)
            begin
                step_next            = 3'd0;
                step_result.done_res = 1'b1;
            end
            else
            begin
                step_next = 3'd1;
                emit      = 1'b1;
            end
        end
        else if (step_reg != 3'd0)
        begin
            // Absorb the byte for the outstanding request
            unique case (cur_op)
                cfs_pkg::CYC_BR:
                begin
                    rb_next[7:0]  = item.bus_data;
                    pc_next[15:0] = pcw_inc;
                    if (branch_taken(kind_reg, flags_reg))
                    begin
                        page_next     = pcw_inc[15:8];
                        oa_next       = {8'h00, br_target};
                        pc_next[15:0] = br_target;
                    end
                end
                cfs_pkg::CYC_FRL:
                begin
                    rb_next[7:0]  = item.bus_data;
                    pc_next[15:0] = pcw_inc;
                end
                cfs_pkg::CYC_FRH:
                begin
                    rb_next[15:8] = item.bus_data;
                    pc_next[15:0] = pcw_inc;
                end
                cfs_pkg::CYC_FRB:
                begin
                    rb_next[23:16] = item.bus_data;
                    pc_next[15:0]  = pcw_inc;
                end
                cfs_pkg::CYC_FAL:
                begin
                    oa_next[7:0]  = item.bus_data;
                    pc_next[15:0] = pcw_inc;
                end
                cfs_pkg::CYC_FAH:
                begin
                    oa_next[15:8] = item.bus_data;
                    pc_next[15:0] = pcw_inc;
                end
                cfs_pkg::CYC_FAB:
                begin
                    oa_next[23:16] = item.bus_data;
                    pc_next[15:0]  = pcw_inc;
                end
                cfs_pkg::CYC_R0L, cfs_pkg::CYC_RPL, cfs_pkg::CYC_PLL:
                begin
                    rb_next[7:0] = item.bus_data;
                end
                cfs_pkg::CYC_R0H, cfs_pkg::CYC_RPH, cfs_pkg::CYC_PLH:
                begin
                    rb_next[15:8] = item.bus_data;
                end
                cfs_pkg::CYC_R0B, cfs_pkg::CYC_PLB:
                begin
                    rb_next[23:16] = item.bus_data;
                end
                cfs_pkg::CYC_PSHD:
                begin
                    pc_next[15:0] = pcw_dec;
                end
                cfs_pkg::CYC_PLP:
                begin
                    step_result.status_load      = 1'b1;
                    step_result.status_value     = status_word;
                    step_result.clear_index_high = status_word[4];
                end
                default:
                begin
                end
            endcase

            if (is_last(kind_reg, {1'b0, step_reg}, flags_reg, emu_reg))
            begin
                // Retire: load the new program counter
                unique case (kind_reg)
                    cfs_pkg::KIND_BRL:
                        pc_next[15:0] = pc_next[15:0] + rb_next[15:0];
                    cfs_pkg::KIND_JMP_ABS, cfs_pkg::KIND_JMP_IND,
                    cfs_pkg::KIND_JMP_IDX, cfs_pkg::KIND_JSR_IDX:
                        pc_next[15:0] = rb_next[15:0];
                    cfs_pkg::KIND_JML_LONG, cfs_pkg::KIND_JML_IND:
                        pc_next = rb_next;
                    cfs_pkg::KIND_JSR_ABS:
                        pc_next[15:0] = oa_next[15:0];
                    cfs_pkg::KIND_JSL:
                        pc_next = oa_next;
                    cfs_pkg::KIND_RTI:
                    begin
                        if (emu_reg)
                        begin
                            pc_next[15:0] = rb_next[15:0];
                        end
                        else
                        begin
                            pc_next = rb_next;
                        end
                    end
                    cfs_pkg::KIND_RTS:
                        pc_next[15:0] = rb_next[15:0] + 16'd1;
                    cfs_pkg::KIND_RTL:
                        pc_next = {rb_next[23:16], rb_next[15:0] + 16'd1};
                    default:
                    begin
                    end
                endcase
                step_next            = 3'd0;
                step_result.done_res = 1'b1;
            end
            else
            begin
                // Advance; drop the page-cross cycle unless it is needed
                seq_step = {1'b0, step_reg} + 4'd1;
                if (cfs_pkg::prog_op(kind_reg, seq_step) == cfs_pkg::CYC_C6 &&
                    !(emu_reg && page_next != oa_next[15:8]))
                begin
                    seq_step = seq_step + 4'd1;
                end
                step_next = seq_step[2:0];
                emit      = 1'b1;
            end
        end

        // Issue the request for the cycle now outstanding
        req_op      = cfs_pkg::prog_op(kind_next, {1'b0, step_next});
        aw          = oa_next[15:0];
        aw_idx      = aw + index_next;
        req_pcw     = pc_next[15:0];
        req_pcw_dec = req_pcw - 16'd1;
        if (emit)
        begin
            step_result.bus_kind    = cfs_pkg::BUS_IDLE;
            step_result.final_cycle = is_last(kind_next, {1'b0, step_next},
                                              flags_next, emu_next);
            unique case (req_op)
                cfs_pkg::CYC_BR, cfs_pkg::CYC_FRL, cfs_pkg::CYC_FRH, cfs_pkg::CYC_FRB,
                cfs_pkg::CYC_FAL, cfs_pkg::CYC_FAH, cfs_pkg::CYC_FAB:
                begin
                    step_result.bus_kind    = cfs_pkg::BUS_FETCH;
                    step_result.bus_address = pc_next;
                end
                cfs_pkg::CYC_R0L:
                begin
                    step_result.bus_kind    = cfs_pkg::BUS_BANK0;
                    step_result.bus_address = {8'h00, aw};
                end
                cfs_pkg::CYC_R0H:
                begin
                    step_result.bus_kind    = cfs_pkg::BUS_BANK0;
                    step_result.bus_address = {8'h00, aw + 16'd1};
                end
                cfs_pkg::CYC_R0B:
                begin
                    step_result.bus_kind    = cfs_pkg::BUS_BANK0;
                    step_result.bus_address = {8'h00, aw + 16'd2};
                end
                cfs_pkg::CYC_RPL:
                begin
                    step_result.bus_kind    = cfs_pkg::BUS_PBANK;
                    step_result.bus_address = {pc_next[23:16], aw_idx};
                end
                cfs_pkg::CYC_RPH:
                begin
                    step_result.bus_kind    = cfs_pkg::BUS_PBANK;
                    step_result.bus_address = {pc_next[23:16], aw_idx + 16'd1};
                end
                cfs_pkg::CYC_PSB:
                begin
                    step_result.bus_kind  = cfs_pkg::BUS_PUSH;
                    step_result.push_byte = pc_next[23:16];
                end
                cfs_pkg::CYC_PSHD:
                begin
                    step_result.bus_kind  = cfs_pkg::BUS_PUSH;
                    step_result.push_byte = req_pcw_dec[15:8];
                end
                cfs_pkg::CYC_PSH:
                begin
                    step_result.bus_kind  = cfs_pkg::BUS_PUSH;
                    step_result.push_byte = req_pcw[15:8];
                end
                cfs_pkg::CYC_PSL:
                begin
                    step_result.bus_kind  = cfs_pkg::BUS_PUSH;
                    step_result.push_byte = req_pcw[7:0];
                end
                cfs_pkg::CYC_PLP, cfs_pkg::CYC_PLL, cfs_pkg::CYC_PLH, cfs_pkg::CYC_PLB:
                begin
                    step_result.bus_kind = cfs_pkg::BUS_PULL;
                end
                default:
                begin
                    step_result.bus_kind = cfs_pkg::BUS_IDLE;
                end
            endcase
        end

        step_result.new_pc = pc_next;
    end

    // Hold the instruction state; advance once per executed cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 3'd0;
            kind_reg  <= 5'd0;
            pc_reg    <= 24'h000000;
            oa_reg    <= 24'h000000;
            rb_reg    <= 24'h000000;
            page_reg  <= 8'h00;
            flags_reg <= 8'h00;
            emu_reg   <= 1'b0;
            index_reg <= 16'h0000;
        end
        else if (fire)
        begin
            step_reg  <= step_next;
            kind_reg  <= kind_next;
            pc_reg    <= pc_next;
            oa_reg    <= oa_next;
            rb_reg    <= rb_next;
            page_reg  <= page_next;
            flags_reg <= flags_next;
            emu_reg   <= emu_next;
            index_reg <= index_next;
        end
    end

    `CFS_ASSERT(a_step_in_program, (step_reg == 3'd0) ||
        (kind_reg < cfs_pkg::NUM_KINDS &&
         cfs_pkg::prog_op(kind_reg, {1'b0, step_reg}) != cfs_pkg::CYC_END),
        "outstanding step lies outside the instruction program")
    `CFS_ASSERT_NEXT(a_done_goes_idle, fire && step_result.done_res,
        step_reg == 3'd0, "instruction retired but sequencer still busy")
    `CFS_ASSERT_NEXT(a_start_enters_first, fire && !item.mode &&
        item.op_kind < cfs_pkg::NUM_KINDS, step_reg == 3'd1,
        "valid start did not enter the first cycle")

endmodule

`default_nettype wire

// ===== design/cfs_out_stage.sv =====
`default_nettype none

module cfs_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire cfs_pkg::result_t data,
    output logic                  slot_free,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output cfs_pkg::result_t      result
);

    logic             valid_reg;
    logic             valid_next;
    cfs_pkg::result_t data_reg;

    // Slot frees up when empty or when the current result transfers
    assign slot_free = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the new result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

`default_nettype wire

// ===== design/cpu_control_flow_sequencer.sv =====
// Control-flow sequencer for a 65816-style CPU: branches, jumps, calls, returns.
// Input channel item_valid / item_ready / item: one transfer per CPU bus cycle.
//   mode 0 starts an instruction (and aborts any running one); mode 1 returns
//   the byte for the previous request in bus_data.
// Output channel result_valid / result_ready / result: exactly one result per
//   item, giving the next bus request, the last-cycle mark, done and new_pc,
//   and on RTI the restored status word.
// Path: the transfer loads the input register, and the result register is loaded
//   from it once the result register has room (slot_free). Throughput: one item per
//   cycle while result_ready stays high; the next item only needs the state left
//   by the previous one, which is updated in the same edge that loads its result.
// Reset clears the sequencer to idle with all latched state zero and both
//   registers empty.
// Stall: a result waiting on result_ready holds its value; one more item waits
//   in the input register, after which item_ready goes low.
`default_nettype none

module cpu_control_flow_sequencer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire cfs_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output cfs_pkg::result_t      result
);

    logic             held_valid;
    cfs_pkg::item_t   held_item;
    logic             slot_free;
    logic             advance;
    cfs_pkg::result_t step_result;

    // Execute the held item when the result register can take it
    assign advance = held_valid && slot_free;

    cfs_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    cfs_exec u_exec (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .item        (held_item),
        .step_result (step_result)
    );

    cfs_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .data         (step_result),
        .slot_free    (slot_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire
